### hdl/mbilp_pkg.sv
// Shared types, codes and character constants for the integer literal parser.
`timescale 1ns / 1ps
`default_nettype none
package mbilp_pkg;

   // literal parse phase
   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_MINUS = 3'd1,
      PH_ZERO  = 3'd2,
      PH_BODY  = 3'd3,
      PH_STOP  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      B_BIN = 2'd0,
      B_OCT = 2'd1,
      B_DEC = 2'd2,
      B_HEX = 2'd3
   } base_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_OVF   = 3'd1,
      ST_NODIG = 3'd2,
      ST_BASE  = 3'd3,
      ST_SIZE  = 3'd4,
      ST_NAN   = 3'd5
   } status_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_1      = 8'h31;
   localparam logic [7:0] CH_7      = 8'h37;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_D  = 8'h64;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_I  = 8'h69;
   localparam logic [7:0] CH_LOW_O  = 8'h6F;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CASE_BIT  = 8'h20;
   localparam logic [3:0] HEX_TEN   = 4'hA;
   localparam logic [7:0] DEST_RESET = 8'd32;
   localparam logic [6:0] BC_SAT    = 7'd127;

   localparam int VALUE_W = 64;

   // per-literal control state, everything except the accumulator
   typedef struct packed {
      phase_type  phase;
      logic [6:0] bit_count;
      status_type error_code;
      base_type   chosen_base;
      logic       minus_seen;
      logic       any_digit;
      logic       body_started;
   } ctl_state_type;

   localparam ctl_state_type CTL_CLEAR = '{
      phase:        PH_START,
      bit_count:    7'd0,
      error_code:   ST_OK,
      chosen_base:  B_DEC,
      minus_seen:   1'b0,
      any_digit:    1'b0,
      body_started: 1'b0
   };

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
      base_type           base_code;
      logic               negative;
   } result_type;

   // smallest container (8/16/32/64) that holds a width
   function automatic int acc_width(input int w);
      int r;
      if (w <= 8) r = 8;
      else if (w <= 16) r = 16;
      else if (w <= 32) r = 32;
      else r = 64;
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/mbilp_step.sv
// Per-character next-state and end-of-literal result logic.
`timescale 1ns / 1ps
`default_nettype none
module mbilp_step #(
   parameter int MAX_WIDTH = 64,
   parameter int ACC_W     = 64
) (
   input  mbilp_pkg::ctl_state_type cur_state,
   input  logic [ACC_W-1:0]         acc_cur,
   input  logic [7:0]               char_code,
   input  logic [7:0]               dest_bits,
   output mbilp_pkg::ctl_state_type nxt_state,
   output logic [ACC_W-1:0]         acc_nxt,
   output mbilp_pkg::result_type    result
);
   import mbilp_pkg::*;

   localparam logic [7:0] MAX_W8 = 8'(MAX_WIDTH);

   logic             do_body;
   logic             ok;
   logic [3:0]       dig;
   logic [2:0]       k;
   logic [7:0]       folded;
   logic [7:0]       bc_sum;
   logic [ACC_W-1:0] mask;
   logic [63:0]      mask64;
   status_type       st;

   assign folded = char_code | CASE_BIT;

   always_comb begin
      nxt_state = cur_state;
      acc_nxt   = acc_cur;
      do_body   = 1'b0;
      ok        = 1'b0;
      dig       = 4'd0;
      k         = 3'd0;
      bc_sum    = 8'd0;

      unique case (cur_state.phase)
         PH_START, PH_MINUS: begin
            if (char_code == CH_MINUS && cur_state.phase == PH_START) begin
               nxt_state.minus_seen = 1'b1;
               nxt_state.phase      = PH_MINUS;
            end else if (char_code >= CH_1 && char_code <= CH_9) begin
               nxt_state.chosen_base = B_DEC;
               nxt_state.phase       = PH_BODY;
               do_body               = 1'b1;
            end else if (char_code == CH_0) begin
               // provisionally a decimal body that starts with this zero
               nxt_state.chosen_base  = B_DEC;
               nxt_state.any_digit    = 1'b1;
               nxt_state.body_started = 1'b1;
               nxt_state.phase        = PH_ZERO;
               acc_nxt                = '0;
            end else begin
               nxt_state.error_code = ST_NAN;
               nxt_state.phase      = PH_STOP;
            end
         end
         PH_ZERO: begin
            nxt_state.phase = PH_BODY;
            if (char_code == CH_LOW_B || char_code == CH_LOW_O || char_code == CH_LOW_D ||
                char_code == CH_LOW_I || char_code == CH_LOW_X) begin
               priority if (char_code == CH_LOW_B) nxt_state.chosen_base = B_BIN;
               else if (char_code == CH_LOW_O) nxt_state.chosen_base = B_OCT;
               else if (char_code == CH_LOW_X) nxt_state.chosen_base = B_HEX;
               else nxt_state.chosen_base = B_DEC;
               nxt_state.any_digit    = 1'b0;
               nxt_state.body_started = 1'b0;
               nxt_state.bit_count    = 7'd0;
               acc_nxt                = '0;
            end else begin
               do_body = 1'b1;
            end
         end
         PH_BODY: do_body = 1'b1;
         PH_STOP: ;
         default: ;
      endcase

      if (do_body) begin
         if (char_code == CH_UNDER && nxt_state.body_started) begin
            // separator, skipped
         end else if (char_code == CH_NUL) begin
            nxt_state.phase = PH_STOP;
         end else begin
            nxt_state.body_started = 1'b1;
            unique case (nxt_state.chosen_base)
               B_BIN: begin
                  k   = 3'd1;
                  ok  = (char_code == CH_0 || char_code == CH_1);
                  dig = 4'(char_code - CH_0);
               end
               B_OCT: begin
                  k   = 3'd3;
                  ok  = (char_code >= CH_0 && char_code <= CH_7);
                  dig = 4'(char_code - CH_0);
               end
               B_HEX: begin
                  k = 3'd4;
                  if (char_code >= CH_0 && char_code <= CH_9) begin
                     ok  = 1'b1;
                     dig = 4'(char_code - CH_0);
                  end else if (folded >= CH_LOW_A && folded <= CH_LOW_F) begin
                     ok  = 1'b1;
                     dig = 4'(folded - CH_LOW_A) + HEX_TEN;
                  end
               end
               B_DEC: begin
                  ok  = (char_code >= CH_0 && char_code <= CH_9);
                  dig = 4'(char_code - CH_0);
               end
            endcase

            if (!ok) begin
               nxt_state.error_code = ST_BASE;
               nxt_state.phase      = PH_STOP;
            end else begin
               nxt_state.any_digit = 1'b1;
               if (nxt_state.chosen_base == B_DEC) begin
                  // x10 as x8 + x2, wraps at the accumulator width
                  acc_nxt = (acc_nxt << 3) + (acc_nxt << 1) + ACC_W'(dig);
               end else begin
                  acc_nxt = (acc_nxt << k) | ACC_W'(dig);
                  if (nxt_state.bit_count != 7'd0 || dig != 4'd0) begin
                     bc_sum = 8'(nxt_state.bit_count) + 8'(k);
                     nxt_state.bit_count = (bc_sum > 8'(BC_SAT)) ? BC_SAT : bc_sum[6:0];
                  end
               end
            end
         end
      end
   end

   // status from the post-update state, in precedence order
   always_comb begin
      priority if (nxt_state.phase == PH_START || nxt_state.phase == PH_MINUS) st = ST_NAN;
      else if (nxt_state.error_code == ST_NAN) st = ST_NAN;
      else if (dest_bits > MAX_W8) st = ST_SIZE;
      else if (nxt_state.error_code == ST_BASE) st = ST_BASE;
      else if (!nxt_state.any_digit) st = ST_NODIG;
      else if (nxt_state.chosen_base != B_DEC && 8'(nxt_state.bit_count) > dest_bits)
         st = ST_OVF;
      else st = ST_OK;
   end

   always_comb begin
      priority if (dest_bits <= 8'd8) mask64 = 64'h0000_0000_0000_00FF;
      else if (dest_bits <= 8'd16) mask64 = 64'h0000_0000_0000_FFFF;
      else if (dest_bits <= 8'd32) mask64 = 64'h0000_0000_FFFF_FFFF;
      else mask64 = 64'hFFFF_FFFF_FFFF_FFFF;
   end

   assign mask = mask64[ACC_W-1:0];

   always_comb begin
      result.value     = (st == ST_OK) ? VALUE_W'(acc_nxt & mask) : '0;
      result.status    = st;
      result.base_code = (st == ST_NAN) ? B_DEC : nxt_state.chosen_base;
      result.negative  = nxt_state.minus_seen;
   end

endmodule
`default_nettype wire

### hdl/multi_base_integer_literal_parser.sv
// Top level of the multi-base integer literal parser.
//
// Input stream (req_*): one ASCII character per beat in req_tdata, req_tlast
// on the final character of a literal. Only the beat carrying tlast produces
// a result; all other beats only advance the parse state.
// Result stream (rsp_*): one beat per literal holding value, status,
// base_code and negative (see the rsp_tdata port comment for bit positions).
// Config: csr_wr_en/csr_wr_data load the 8-bit destination width
// (reset 32); write only while no literal is in flight.
//
// The tlast beat goes from the input register through one combinational step
// into the result register, which drives rsp_tvalid; it waits in the input
// register while the result register is full. Throughput: one character per
// cycle, back to back, across literals, while no tlast beat waits; the character
// step (shift-or, or x10 add) and status decode are combinational.
//
// Reset clears both pipeline valids, the parse state and sets the width to
// 32. When the receiver stalls the result register holds; characters keep
// flowing until a second tlast beat reaches the step stage, which then waits
// in the input register and back-pressures req_tready.
`timescale 1ns / 1ps
`default_nettype none
module multi_base_integer_literal_parser #(
   parameter int MAX_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // slave side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_code
   input  logic        req_tlast,    // last_char
   // master side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // [63:0] value, [66:64] status,
                                     // [68:67] base_code, [69] negative, [71:70] zero
   // config
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data   // dest_bits
);
   import mbilp_pkg::*;

   localparam int ACC_W = acc_width(MAX_WIDTH);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // parse state
   ctl_state_type    state_ff, state_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   logic [7:0] dest_bits_ff;

   ctl_state_type    step_state;
   logic [ACC_W-1:0] step_acc;
   result_type       step_result;

   logic out_free;
   logic step_fire;
   logic req_beat;

   mbilp_step #(
      .MAX_WIDTH (MAX_WIDTH),
      .ACC_W     (ACC_W)
   ) u_step (
      .cur_state (state_ff),
      .acc_cur   (acc_ff),
      .char_code (in_char_ff),
      .dest_bits (dest_bits_ff),
      .nxt_state (step_state),
      .acc_nxt   (step_acc),
      .result    (step_result)
   );

   // a closing beat needs the result slot; other beats never wait
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step_fire;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_beat || (in_valid_ff && !step_fire);
      state_in     = state_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (step_fire) begin
         if (in_last_ff) begin
            // literal done: back to the clean state
            state_in     = CTL_CLEAR;
            acc_in       = '0;
            rsp_valid_in = 1'b1;
         end else begin
            state_in = step_state;
            acc_in   = step_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= CTL_CLEAR;
         acc_ff       <= '0;
         dest_bits_ff <= DEST_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         if (csr_wr_en) begin
            dest_bits_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step_fire && in_last_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.negative, rsp_data_ff.base_code,
                        rsp_data_ff.status, rsp_data_ff.value};

endmodule
`default_nettype wire
